[rtl/core/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants shared by the tick task scheduler and its table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int MAX_RESULTS   = 16;

  localparam int DATA_W    = 32;
  localparam int MODE_W    = 2;
  localparam int PEND_W    = 8;
  localparam int IDX_OUT_W = 4;
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [PEND_W-1:0] PENDING_MAX = {PEND_W{1'b1}};

  // entry modes
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DONE     = 2'd2;

  // result kinds
  localparam logic RES_ACK = 1'b0;
  localparam logic RES_RUN = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_TICK     = 2'd1,
    KIND_DISPATCH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WALK  = 2'd1,
    ST_FLUSH = 2'd2
  } state_e;

  // control broadcast from the sequencer to one cell
  typedef struct packed {
    logic wr;       // store the add word in this cell
    logic tick;     // apply one tick to this cell
    logic consume;  // walk step takes a pending run from the token holder
    logic shift;    // move the walk token one cell along
    logic clr;      // drop the walk token
  } cell_ctrl_t;

  // status from one cell back to the sequencer
  typedef struct packed {
    logic tok;
    logic pend_nz;
    logic runnable;
  } cell_stat_t;

endpackage

`default_nettype wire

[rtl/core/tts_cell.sv]
// ----------------------------------------------------------------------------
// tts_cell
// One table entry: delay countdown, reload period, pending runs and mode,
// plus one stage of the walk token chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  tts_pkg::cell_ctrl_t        ctrl_i,
  input  wire  [tts_pkg::DATA_W-1:0]       delay_i,
  input  wire  [tts_pkg::DATA_W-1:0]       period_i,
  input  wire  [tts_pkg::MODE_W-1:0]       mode_i,
  input  wire                              tok_i,
  output logic                             tok_o,
  output tts_pkg::cell_stat_t              stat_o
);

  logic [tts_pkg::DATA_W-1:0] delay_q,  delay_d;
  logic [tts_pkg::DATA_W-1:0] period_q, period_d;
  logic [tts_pkg::PEND_W-1:0] pend_q,   pend_d;
  logic [tts_pkg::MODE_W-1:0] mode_q,   mode_d;
  logic                       tok_q,    tok_d;
  logic                       pend_nz;
  logic                       runnable;

  assign pend_nz  = (pend_q != '0);
  assign runnable = (mode_q == tts_pkg::MODE_PERIODIC) ||
                    (mode_q == tts_pkg::MODE_ONESHOT);

  always_comb begin
    delay_d  = delay_q;
    period_d = period_q;
    pend_d   = pend_q;
    mode_d   = mode_q;
    if (ctrl_i.wr) begin
      delay_d  = delay_i;
      period_d = period_i;
      mode_d   = mode_i;
      pend_d   = (delay_i == '0) ? tts_pkg::PEND_W'(1) : '0;
    end else if (ctrl_i.tick) begin
      if (delay_q != '0) begin
        delay_d = delay_q - tts_pkg::DATA_W'(1);
      end else begin
        delay_d = period_q;
        if (pend_q != tts_pkg::PENDING_MAX) begin
          pend_d = pend_q + tts_pkg::PEND_W'(1);
        end
      end
    end else if (ctrl_i.consume && tok_q && pend_nz) begin
      pend_d = pend_q - tts_pkg::PEND_W'(1);
      if (mode_q == tts_pkg::MODE_ONESHOT) begin
        mode_d = tts_pkg::MODE_DONE;
      end
    end
  end

  always_comb begin
    tok_d = tok_q;
    if (ctrl_i.clr) begin
      tok_d = 1'b0;
    end else if (ctrl_i.shift) begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // entry payload has no reset, it is written by an add before use
  always_ff @(posedge clk_i) begin
    delay_q  <= delay_d;
    period_q <= period_d;
    pend_q   <= pend_d;
    mode_q   <= mode_d;
  end

  assign tok_o           = tok_q;
  assign stat_o.tok      = tok_q;
  assign stat_o.pend_nz  = pend_nz;
  assign stat_o.runnable = runnable;

endmodule

`default_nettype wire

[rtl/core/tick_task_scheduler.sv]
// ----------------------------------------------------------------------------
// tick_task_scheduler
// Table of timed tasks held in a row of cells; add, tick and dispatch words
// in, add acknowledgements and run indices out.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                     tuser        tlast
//  s_axis   in   delay[31:0] period[63:32] mode[65:64]  kind[1:0]    -
//  m_axis   out  task_index[3:0] table_full[4]          result_kind  last result
//
//  add: a free entry is written, then the ack leaves through the output
//  register. tick: every added entry updates in parallel. dispatch: a
//  token walks the cell chain one entry a cycle for task_count entries or
//  MAX_RESULTS runs, then the last result goes out. The walk pauses while
//  the output register is full and a new run needs its slot. No input word
//  is taken while an add or dispatch is still in progress. Reset clears the
//  task count and the walk token; entries are valid only once added.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_task_scheduler #(
  parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,   // delay[31:0], period[63:32], run_mode[65:64]
  input  wire  [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // task_index[3:0], table_full[4]
  output logic        m_axis_tuser,   // result_kind[0]
  output logic        m_axis_tlast
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int OW    = tts_pkg::IDX_OUT_W;
  localparam logic [OW-1:0]    FULL_IDX = OW'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TASKS);

  tts_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              widx_q,  widx_d;
  logic [tts_pkg::RES_CNT_W-1:0] nres_q,  nres_d;

  logic          hold_valid_q, hold_valid_d;
  logic          hold_kind_q,  hold_kind_d;
  logic [OW-1:0] hold_idx_q,   hold_idx_d;
  logic          hold_full_q,  hold_full_d;

  logic          out_valid_q, out_valid_d;
  logic          out_kind_q,  out_kind_d;
  logic [OW-1:0] out_idx_q,   out_idx_d;
  logic          out_full_q,  out_full_d;
  logic          out_last_q,  out_last_d;

  logic [tts_pkg::DATA_W-1:0] in_delay;
  logic [tts_pkg::DATA_W-1:0] in_period;
  logic [tts_pkg::MODE_W-1:0] in_mode;
  logic [1:0]                 in_kind;

  logic in_acc, is_add, is_tick, is_disp, tbl_full;
  logic out_free, walk_end, sel_pend, sel_run, stall, step, report;

  logic [CNT_W+OW-1:0] count_ext, widx_ext;

  tts_pkg::cell_ctrl_t cell_ctrl [MAX_TASKS];
  tts_pkg::cell_stat_t cell_stat [MAX_TASKS];
  logic [MAX_TASKS:0]  tok_chain;
  logic [MAX_TASKS-1:0] tok_pend, tok_run;

  assign in_delay  = s_axis_tdata[31:0];
  assign in_period = s_axis_tdata[63:32];
  assign in_mode   = s_axis_tdata[65:64];
  assign in_kind   = s_axis_tuser;

  assign s_axis_tready = (state_q == tts_pkg::ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_add   = in_acc && (in_kind == tts_pkg::KIND_ADD);
  assign is_tick  = in_acc && (in_kind == tts_pkg::KIND_TICK);
  assign is_disp  = in_acc && (in_kind == tts_pkg::KIND_DISPATCH);
  assign tbl_full = (count_q == CNT_MAX);

  assign count_ext = {{OW{1'b0}}, count_q};
  assign widx_ext  = {{OW{1'b0}}, widx_q};

  assign out_free = !out_valid_q || m_axis_tready;

  // token holder status, only one cell holds the token
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      tok_pend[i] = cell_stat[i].tok && cell_stat[i].pend_nz;
      tok_run[i]  = cell_stat[i].tok && cell_stat[i].runnable;
    end
  end

  assign sel_pend = |tok_pend;
  assign sel_run  = |tok_run;
  assign walk_end = (widx_q == count_q) ||
                    (nres_q == tts_pkg::RES_CNT_W'(tts_pkg::MAX_RESULTS));
  // a new run pushes the held one out, so it needs the output slot
  assign stall    = sel_pend && sel_run && hold_valid_q && !out_free;
  assign step     = (state_q == tts_pkg::ST_WALK) && !walk_end && !stall;
  assign report   = step && sel_pend && sel_run;

  // cell chain
  assign tok_chain[0] = is_disp;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    always_comb begin
      cell_ctrl[g].wr      = is_add && !tbl_full && (count_q[IW-1:0] == IW'(g));
      cell_ctrl[g].tick    = is_tick && (CNT_W'(g) < count_q);
      cell_ctrl[g].consume = step && sel_pend;
      cell_ctrl[g].shift   = is_disp || step;
      cell_ctrl[g].clr     = (state_q == tts_pkg::ST_WALK) && walk_end;
    end

    tts_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl[g]),
      .delay_i  (in_delay),
      .period_i (in_period),
      .mode_i   (in_mode),
      .tok_i    (tok_chain[g]),
      .tok_o    (tok_chain[g+1]),
      .stat_o   (cell_stat[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tts_pkg::ST_IDLE: begin
        if (is_add) begin
          state_d = tts_pkg::ST_FLUSH;
        end else if (is_disp) begin
          state_d = tts_pkg::ST_WALK;
        end
      end
      tts_pkg::ST_WALK: begin
        if (walk_end) begin
          state_d = hold_valid_q ? tts_pkg::ST_FLUSH : tts_pkg::ST_IDLE;
        end
      end
      tts_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_d = tts_pkg::ST_IDLE;
        end
      end
      default: state_d = tts_pkg::ST_IDLE;
    endcase
  end

  // counters, held result and output register
  always_comb begin
    count_d      = count_q;
    widx_d       = widx_q;
    nres_d       = nres_q;
    hold_valid_d = hold_valid_q;
    hold_kind_d  = hold_kind_q;
    hold_idx_d   = hold_idx_q;
    hold_full_d  = hold_full_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_kind_d   = out_kind_q;
    out_idx_d    = out_idx_q;
    out_full_d   = out_full_q;
    out_last_d   = out_last_q;

    if (is_add) begin
      hold_valid_d = 1'b1;
      hold_kind_d  = tts_pkg::RES_ACK;
      if (tbl_full) begin
        hold_idx_d  = FULL_IDX;
        hold_full_d = 1'b1;
      end else begin
        hold_idx_d  = count_ext[OW-1:0];
        hold_full_d = 1'b0;
        count_d     = count_q + CNT_W'(1);
      end
    end

    if (is_disp) begin
      widx_d = '0;
      nres_d = '0;
    end

    if (step) begin
      widx_d = widx_q + CNT_W'(1);
    end

    if (report) begin
      // earlier run is not the last one, send it on
      if (hold_valid_q) begin
        out_valid_d = 1'b1;
        out_kind_d  = hold_kind_q;
        out_idx_d   = hold_idx_q;
        out_full_d  = hold_full_q;
        out_last_d  = 1'b0;
      end
      hold_valid_d = 1'b1;
      hold_kind_d  = tts_pkg::RES_RUN;
      hold_idx_d   = widx_ext[OW-1:0];
      hold_full_d  = 1'b0;
      nres_d       = nres_q + tts_pkg::RES_CNT_W'(1);
    end

    if ((state_q == tts_pkg::ST_FLUSH) && out_free) begin
      out_valid_d  = 1'b1;
      out_kind_d   = hold_kind_q;
      out_idx_d    = hold_idx_q;
      out_full_d   = hold_full_q;
      out_last_d   = 1'b1;
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tts_pkg::ST_IDLE;
      count_q      <= '0;
      widx_q       <= '0;
      nres_q       <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      widx_q       <= widx_d;
      nres_q       <= nres_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_kind_q <= hold_kind_d;
    hold_idx_q  <= hold_idx_d;
    hold_full_q <= hold_full_d;
    out_kind_q  <= out_kind_d;
    out_idx_q   <= out_idx_d;
    out_full_q  <= out_full_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_full_q, out_idx_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
